// ===== src/sorted_timer_queue_top_assert.svh =====
// ---------------------------------------------------------------------------
// Sorted timer queue assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef SORTED_TIMER_QUEUE_TOP_ASSERT_SVH
`define SORTED_TIMER_QUEUE_TOP_ASSERT_SVH

// The expression holds at every clock edge outside reset.
`define STQ_ASSERT_ALWAYS(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("sorted timer queue: invariant violated");

// The consequent holds in the cycle after the antecedent.
`define STQ_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sorted timer queue: sequence violated");

`endif

// ===== src/stq_pkg.sv =====
// ---------------------------------------------------------------------------
// Sorted timer queue package
// Shared constants, payload types and control types of the timer queue.
// ---------------------------------------------------------------------------
package stq_pkg;

   localparam int NUM_TIMERS   = 16;
   localparam int ID_W         = 4;
   localparam int TIME_W       = 32;
   localparam int RESULT_LIMIT = 16;
   localparam int POP_W        = $clog2(RESULT_LIMIT);

   typedef enum logic [1:0] {
      CMD_START_REL = 2'd0,
      CMD_START_ABS = 2'd1,
      CMD_STOP      = 2'd2,
      CMD_PROCESS   = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type             cmd;
      logic [ID_W-1:0]     timer_id;
      logic [TIME_W-1:0]   time_value;
      logic [TIME_W-1:0]   now;
   } req_payload_type;

   typedef struct packed {
      logic [ID_W-1:0]     fired_timer;
      logic                fired_valid;
      logic [TIME_W-1:0]   earliest_time;
      logic                last;
   } rsp_payload_type;

   // One queue slot.
   typedef struct packed {
      logic                valid;
      logic [ID_W-1:0]     id;
      logic [TIME_W-1:0]   fire_time;
   } entry_type;

   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_REMOVE = 2'd1,
      OP_INSERT = 2'd2
   } cell_op_type;

   // Broadcast to every cell of the chain.
   typedef struct packed {
      cell_op_type         op;
      logic [ID_W-1:0]     id;
      logic [TIME_W-1:0]   fire_time;
   } cell_ctrl_type;

   // What the controller sees of the chain.
   typedef struct packed {
      entry_type           head;
      entry_type           second;
      logic                full;
   } chain_status_type;

   typedef enum logic [2:0] {
      ST_IDLE    = 3'd0,
      ST_REMOVE  = 3'd1,
      ST_INSERT  = 3'd2,
      ST_STATUS  = 3'd3,
      ST_PROCESS = 3'd4
   } state_type;

endpackage

// ===== src/stq_cell.sv =====
// ---------------------------------------------------------------------------
// Sorted timer queue cell
// One slot of the sorted chain; shifts toward the head on removal and
// toward the tail on insertion.
// ---------------------------------------------------------------------------
module stq_cell
   import stq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  entry_type     left_entry,
   input  entry_type     right_entry,
   input  logic          hit_in,
   input  logic          ins_in,
   output logic          hit_out,
   output logic          ins_out,
   output entry_type     entry
);

   entry_type entry_ff;
   entry_type entry_in;
   entry_type new_entry;

   // The removed timer sits here or nearer the head.
   assign hit_out = hit_in | (entry_ff.valid & (entry_ff.id == ctrl.id));
   // The new timer belongs here or nearer the head.
   assign ins_out = ~entry_ff.valid | (entry_ff.fire_time > ctrl.fire_time);

   always_comb begin
      new_entry.valid     = 1'b1;
      new_entry.id        = ctrl.id;
      new_entry.fire_time = ctrl.fire_time;
      entry_in            = entry_ff;
      case (ctrl.op)
         OP_REMOVE: begin
            if (hit_out) begin
               entry_in = right_entry;
            end
         end
         OP_INSERT: begin
            if (ins_out && ins_in) begin
               entry_in = left_entry;
            end else if (ins_out) begin
               entry_in = new_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

// ===== src/stq_chain.sv =====
// ---------------------------------------------------------------------------
// Sorted timer queue chain
// Row of cells kept sorted by fire time, head at cell zero.
// ---------------------------------------------------------------------------
module stq_chain
   import stq_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cell_ctrl_type    ctrl,
   output chain_status_type status
);

   entry_type cell_q  [NUM_TIMERS];
   entry_type left_e  [NUM_TIMERS];
   entry_type right_e [NUM_TIMERS];
   logic      hit     [NUM_TIMERS+1];
   logic      ins     [NUM_TIMERS+1];

   assign hit[0] = 1'b0;
   assign ins[0] = 1'b0;

   for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
      if (g == 0) begin : g_first
         assign left_e[g] = '0;
      end else begin : g_inner_l
         assign left_e[g] = cell_q[g-1];
      end
      if (g == NUM_TIMERS - 1) begin : g_last
         assign right_e[g] = '0;
      end else begin : g_inner_r
         assign right_e[g] = cell_q[g+1];
      end

      stq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_entry  (left_e[g]),
         .right_entry (right_e[g]),
         .hit_in      (hit[g]),
         .ins_in      (ins[g]),
         .hit_out     (hit[g+1]),
         .ins_out     (ins[g+1]),
         .entry       (cell_q[g])
      );
   end

   assign status.head   = cell_q[0];
   assign status.second = cell_q[1];
   assign status.full   = cell_q[NUM_TIMERS-1].valid;

endmodule

// ===== src/sorted_timer_queue_top.sv =====
// ---------------------------------------------------------------------------
// Sorted timer queue
// Up to sixteen timers held in a shift-insert chain sorted by fire time.
// ---------------------------------------------------------------------------
//
//   Channel  Ports                      Moves per transfer
//   -------  -------------------------  ---------------------------------------
//   request  req_valid/ready/payload    one command: start, stop or process
//   response rsp_valid/ready/payload    one result: fired timer or status
//
// After its transfer, a start takes the timer out of the chain, then inserts
// it, then loads the status result. A stop takes the timer out and loads the
// status result; a process pops each fired timer in turn, or loads a status
// result when nothing is due; the chain moves by one operation per cycle.
// Reset clears every valid bit of the chain and returns the controller to
// idle. A stalled response holds the controller in the state that loads the
// next result; a new request is taken in idle even while the last result
// still waits in the output register.
//
module sorted_timer_queue_top
   import stq_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

`include "sorted_timer_queue_top_assert.svh"

   state_type        state_ff;
   state_type        state_in;

   // The accepted command, with a relative start already turned into an
   // absolute fire time.
   cmd_type           cmd_ff;
   logic [ID_W-1:0]   id_ff;
   logic [TIME_W-1:0] time_ff;
   logic [TIME_W-1:0] now_ff;
   logic [TIME_W:0]   rel_sum;
   logic [TIME_W-1:0] start_time;

   logic [POP_W-1:0]  pop_cnt_ff;
   logic [POP_W-1:0]  pop_cnt_in;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   rsp_payload_type   rsp_data_ff;
   rsp_payload_type   rsp_data_in;

   cell_ctrl_type     ctrl;
   chain_status_type  chain;

   logic              req_xfer;
   logic              out_free;
   logic              id_ok;
   logic              head_due;
   logic              pop_last;
   logic              chain_ordered;
   logic [TIME_W-1:0] head_time;
   logic [TIME_W-1:0] second_time;

   stq_chain u_chain (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .status (chain)
   );

   // A relative start saturates at the largest time instead of wrapping.
   assign rel_sum    = {1'b0, req_payload.now} + {1'b0, req_payload.time_value};
   assign start_time = rel_sum[TIME_W] ? {TIME_W{1'b1}} : rel_sum[TIME_W-1:0];

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_xfer   = req_valid & req_ready;
   assign out_free   = ~rsp_valid_ff | rsp_ready;
   assign id_ok      = int'(id_ff) < NUM_TIMERS;

   assign head_time   = chain.head.valid   ? chain.head.fire_time   : {TIME_W{1'b1}};
   assign second_time = chain.second.valid ? chain.second.fire_time : {TIME_W{1'b1}};
   assign head_due    = chain.head.valid & (chain.head.fire_time <= now_ff);
   // The pop in progress ends the burst when the next head is not due or
   // when the per-command result limit is reached.
   assign pop_last    = ~chain.second.valid | (chain.second.fire_time > now_ff) |
                        (pop_cnt_ff == POP_W'(RESULT_LIMIT - 1));

   // The two front cells are packed and in fire time order.
   assign chain_ordered = ~chain.second.valid |
                          (chain.head.valid & (chain.head.fire_time <= chain.second.fire_time));

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         cmd_ff  <= req_payload.cmd;
         id_ff   <= req_payload.timer_id;
         time_ff <= (req_payload.cmd == CMD_START_REL) ? start_time
                                                       : req_payload.time_value;
         now_ff  <= req_payload.now;
      end
   end

   always_comb begin
      state_in       = state_ff;
      pop_cnt_in     = pop_cnt_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      rsp_data_in    = rsp_data_ff;
      ctrl.op        = OP_HOLD;
      ctrl.id        = id_ff;
      ctrl.fire_time = time_ff;
      case (state_ff)
         ST_IDLE: begin
            pop_cnt_in = '0;
            if (req_xfer) begin
               state_in = (req_payload.cmd == CMD_PROCESS) ? ST_PROCESS : ST_REMOVE;
            end
         end
         ST_REMOVE: begin
            if (id_ok) begin
               ctrl.op = OP_REMOVE;
            end
            state_in = (cmd_ff == CMD_STOP) ? ST_STATUS : ST_INSERT;
         end
         ST_INSERT: begin
            // A full chain drops the restarted timer rather than its tail.
            if (id_ok && !chain.full) begin
               ctrl.op = OP_INSERT;
            end
            state_in = ST_STATUS;
         end
         ST_STATUS: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.fired_timer   = '0;
               rsp_data_in.fired_valid   = 1'b0;
               rsp_data_in.earliest_time = head_time;
               rsp_data_in.last          = 1'b1;
               state_in                  = ST_IDLE;
            end
         end
         ST_PROCESS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (head_due) begin
                  ctrl.op                   = OP_REMOVE;
                  ctrl.id                   = chain.head.id;
                  rsp_data_in.fired_timer   = chain.head.id;
                  rsp_data_in.fired_valid   = 1'b1;
                  rsp_data_in.earliest_time = second_time;
                  rsp_data_in.last          = pop_last;
                  pop_cnt_in                = pop_cnt_ff + POP_W'(1);
                  if (pop_last) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  // Only reached on the first look, when nothing is due.
                  rsp_data_in.fired_timer   = '0;
                  rsp_data_in.fired_valid   = 1'b0;
                  rsp_data_in.earliest_time = head_time;
                  rsp_data_in.last          = 1'b1;
                  state_in                  = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pop_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pop_cnt_ff   <= pop_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // The two front cells of the chain stay sorted and packed toward the head.
   `STQ_ASSERT_ALWAYS(a_chain_sorted, chain_ordered)
   // A status result always closes its command.
   `STQ_ASSERT_ALWAYS(a_status_last, !rsp_valid_ff || rsp_data_ff.fired_valid || rsp_data_ff.last)
   // An accepted command always leaves idle.
   `STQ_ASSERT_NEXT(a_accept_busy, req_xfer, state_ff != ST_IDLE)

endmodule
